// ===== rtl/rdt_pkg.sv =====
// ----------------------------------------------------------------------------
// rdt_pkg
// shared types and constants of the reliable delivery tracker
// ----------------------------------------------------------------------------
package rdt_pkg;

  localparam int unsigned DEF_PENDING_SLOTS   = 16;
  localparam int unsigned DEF_ACK_QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS         = 16;
  localparam logic [15:0] TIMEOUT_RESET       = 16'd2000;

  typedef enum logic [2:0] {
    ACT_SEND  = 3'd0,
    ACT_DATA  = 3'd1,
    ACT_ACK   = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_DRAIN = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_DATA,
    OP_ACK,
    OP_TICK,
    OP_DRAIN,
    OP_NONE
  } op_e;

  typedef enum logic [3:0] {
    K_ASSIGNED    = 4'd0,
    K_FULL        = 4'd1,
    K_ACCEPTED    = 4'd2,
    K_ACK_DROPPED = 4'd3,
    K_REJECTED    = 4'd4,
    K_DELIVERED   = 4'd5,
    K_UNKNOWN     = 4'd6,
    K_TIMED_OUT   = 4'd7,
    K_ACK_OUT     = 4'd8,
    K_NOTHING     = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] seq;
  } item_t;

endpackage

// ===== rtl/reliable_delivery_tracker.sv =====
// send and data words give one result each; ack and tick
// words scan up to PENDING_SLOTS slots one a cycle (a tick scan waits on a stalled output),
// drain reads the ack queue ram one entry a cycle (at most 16, waits on a stalled output)
// a two-word input queue takes new words while the back end works
// async active-low reset clears counters, valid bits and queues; timeout 2000
// ----------------------------------------------------------------------------
// reliable_delivery_tracker
// sequence number, acknowledgement and timeout tracker
// ----------------------------------------------------------------------------
module reliable_delivery_tracker
  import rdt_pkg::*;
#(
  parameter int unsigned PENDING_SLOTS   = DEF_PENDING_SLOTS,
  parameter int unsigned ACK_QUEUE_DEPTH = DEF_ACK_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        timeout_ticks_we_i,
  input  logic [15:0] timeout_ticks_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] seq_num_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [31:0] seq_o,
  output logic        is_last_o
);

  logic [15:0] timeout_q;
  logic        q_valid, q_pop;
  item_t       q_item;
  kind_e       kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (timeout_ticks_we_i) begin
      timeout_q <= timeout_ticks_i;
    end
  end

  rdt_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .action_i(action_i), .seq_num_i(seq_num_i),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  rdt_back #(
    .PENDING_SLOTS(PENDING_SLOTS), .ACK_QUEUE_DEPTH(ACK_QUEUE_DEPTH)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .timeout_i(timeout_q),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_kind_o(kind), .out_seq_o(seq_o), .out_last_o(is_last_o)
  );

  assign kind_o = kind;

endmodule

// ===== rtl/rdt_ram.sv =====
// ----------------------------------------------------------------------------
// rdt_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module rdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rdt_front.sv =====
// ----------------------------------------------------------------------------
// rdt_front
// accepts input words, decodes the action and queues them for the back end
// ----------------------------------------------------------------------------
module rdt_front
  import rdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] seq_num_i,
  output logic        q_valid_o,
  output item_t       q_item_o,
  input  logic        q_pop_i
);

  item_t       ent_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_q, rd_q;
  logic        push;
  item_t       dec;

  always_comb begin
    dec.seq = seq_num_i;
    unique case (action_i)
      ACT_SEND:  dec.op = OP_SEND;
      ACT_DATA:  dec.op = OP_DATA;
      ACT_ACK:   dec.op = OP_ACK;
      ACT_TICK:  dec.op = OP_TICK;
      ACT_DRAIN: dec.op = OP_DRAIN;
      default:   dec.op = OP_NONE;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (q_pop_i && q_valid_o) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= dec;
    end
  end

endmodule

// ===== rtl/rdt_back.sv =====
// ----------------------------------------------------------------------------
// rdt_back
// executes queued words: slot table, ack queue, scans and result output
// ----------------------------------------------------------------------------
module rdt_back
  import rdt_pkg::*;
#(
  parameter int unsigned PENDING_SLOTS   = DEF_PENDING_SLOTS,
  parameter int unsigned ACK_QUEUE_DEPTH = DEF_ACK_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  input  logic [15:0] timeout_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output kind_e       out_kind_o,
  output logic [31:0] out_seq_o,
  output logic        out_last_o
);

  localparam int unsigned SLW  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int unsigned AAW  = (ACK_QUEUE_DEPTH > 1) ? $clog2(ACK_QUEUE_DEPTH) : 1;
  localparam int unsigned ACW  = $clog2(ACK_QUEUE_DEPTH + 1);
  localparam int unsigned SMAX = (PENDING_SLOTS > MAX_RESULTS) ? PENDING_SLOTS : MAX_RESULTS;
  localparam int unsigned SW   = $clog2(SMAX + 1);
  localparam int unsigned NW   = $clog2(MAX_RESULTS + 1);

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [31:0]        cur_seq_q, cur_seq_d;
  logic [31:0]        next_out_q, next_out_d;
  logic [31:0]        next_exp_q, next_exp_d;
  logic [31:0]        now_q, now_d;
  logic [PENDING_SLOTS-1:0] valid_q, valid_d;
  logic [AAW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [ACW-1:0]     acnt_q, acnt_d;
  logic [SW-1:0]      idx_q, idx_d, limit_q, limit_d;
  logic               pend_q, pend_d;
  logic [SLW-1:0]     chk_q, chk_d;
  logic [NW-1:0]      n_q, n_d;
  logic               hold_v_q, hold_v_d;
  kind_e              hold_kind_q, hold_kind_d;
  logic [31:0]        hold_seq_q, hold_seq_d;
  logic               out_v_q, out_v_d;
  kind_e              out_kind_q, out_kind_d;
  logic [31:0]        out_seq_q, out_seq_d;
  logic               out_last_q, out_last_d;

  logic               out_free;
  logic               free_found;
  logic [SLW-1:0]     free_idx;
  logic               slot_we, slot_re, ack_we, ack_re;
  logic [31:0]        seq_rd, start_rd, ack_rd;
  logic               is_hit, blocked, cap_hit, can_issue, scan_fin;

  rdt_ram #(.WIDTH(32), .DEPTH(PENDING_SLOTS)) u_seq_ram (
    .clk_i(clk_i), .we_i(slot_we), .waddr_i(free_idx), .wdata_i(next_out_q),
    .re_i(slot_re), .raddr_i(idx_q[SLW-1:0]), .rdata_o(seq_rd)
  );

  rdt_ram #(.WIDTH(32), .DEPTH(PENDING_SLOTS)) u_start_ram (
    .clk_i(clk_i), .we_i(slot_we), .waddr_i(free_idx), .wdata_i(now_q),
    .re_i(slot_re), .raddr_i(idx_q[SLW-1:0]), .rdata_o(start_rd)
  );

  rdt_ram #(.WIDTH(32), .DEPTH(ACK_QUEUE_DEPTH)) u_ack_ram (
    .clk_i(clk_i), .we_i(ack_we), .waddr_i(tail_q), .wdata_i(q_item_i.seq),
    .re_i(ack_re), .raddr_i(head_q), .rdata_o(ack_rd)
  );

  assign out_free = !out_v_q || !out_stall_i;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLW'(i);
      end
    end
  end

  // scan step status
  always_comb begin
    is_hit = 1'b0;
    unique case (op_q)
      OP_ACK:   is_hit = pend_q && valid_q[chk_q] && (seq_rd == cur_seq_q);
      OP_TICK:  is_hit = pend_q && valid_q[chk_q] &&
                         ((now_q - start_rd) > {16'd0, timeout_i});
      OP_DRAIN: is_hit = pend_q;
      default:  is_hit = 1'b0;
    endcase
    blocked   = (op_q != OP_ACK) && is_hit && hold_v_q && !out_free;
    cap_hit   = is_hit && ((op_q == OP_ACK) || (n_q == NW'(MAX_RESULTS - 1)));
    can_issue = !cap_hit && (idx_q < limit_q);
    scan_fin  = !blocked && !can_issue;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.op == OP_ACK || q_item_i.op == OP_TICK ||
              q_item_i.op == OP_DRAIN) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_fin) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    cur_seq_d   = cur_seq_q;
    next_out_d  = next_out_q;
    next_exp_d  = next_exp_q;
    now_d       = now_q;
    valid_d     = valid_q;
    head_d      = head_q;
    tail_d      = tail_q;
    acnt_d      = acnt_q;
    idx_d       = idx_q;
    limit_d     = limit_q;
    pend_d      = pend_q;
    chk_d       = chk_q;
    n_d         = n_q;
    hold_v_d    = hold_v_q;
    hold_kind_d = hold_kind_q;
    hold_seq_d  = hold_seq_q;
    out_v_d     = out_v_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_seq_d   = out_seq_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    ack_we      = 1'b0;
    ack_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          op_d      = q_item_i.op;
          cur_seq_d = q_item_i.seq;
          hold_v_d  = 1'b0;
          n_d       = '0;
          idx_d     = '0;
          pend_d    = 1'b0;
          limit_d   = SW'(PENDING_SLOTS);
          unique case (q_item_i.op)
            OP_SEND: begin
              hold_v_d = 1'b1;
              if (free_found) begin
                valid_d[free_idx] = 1'b1;
                slot_we     = 1'b1;
                hold_kind_d = K_ASSIGNED;
                hold_seq_d  = next_out_q;
                next_out_d  = next_out_q + 32'd1;
              end else begin
                hold_kind_d = K_FULL;
                hold_seq_d  = '0;
              end
            end
            OP_DATA: begin
              hold_v_d   = 1'b1;
              hold_seq_d = q_item_i.seq;
              if (q_item_i.seq >= next_exp_q) begin
                next_exp_d = q_item_i.seq + 32'd1;
                if (32'(acnt_q) < 32'(ACK_QUEUE_DEPTH)) begin
                  ack_we      = 1'b1;
                  tail_d      = (tail_q == AAW'(ACK_QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                  acnt_d      = acnt_q + 1'b1;
                  hold_kind_d = K_ACCEPTED;
                end else begin
                  hold_kind_d = K_ACK_DROPPED;
                end
              end else begin
                hold_kind_d = K_REJECTED;
              end
            end
            OP_TICK: now_d = now_q + 32'd1;
            OP_DRAIN: begin
              if (32'(acnt_q) > 32'(MAX_RESULTS)) begin
                limit_d = SW'(MAX_RESULTS);
              end else begin
                limit_d = SW'(acnt_q);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!blocked) begin
          if (is_hit) begin
            if (op_q == OP_ACK) begin
              valid_d[chk_q] = 1'b0;
              hold_v_d    = 1'b1;
              hold_kind_d = K_DELIVERED;
              hold_seq_d  = cur_seq_q;
            end else begin
              if (hold_v_q) begin
                out_v_d    = 1'b1;
                out_kind_d = hold_kind_q;
                out_seq_d  = hold_seq_q;
                out_last_d = 1'b0;
              end
              hold_v_d = 1'b1;
              n_d      = n_q + 1'b1;
              if (op_q == OP_TICK) begin
                valid_d[chk_q] = 1'b0;
                hold_kind_d    = K_TIMED_OUT;
                hold_seq_d     = seq_rd;
              end else begin
                hold_kind_d = K_ACK_OUT;
                hold_seq_d  = ack_rd;
              end
            end
          end
          if (can_issue) begin
            idx_d  = idx_q + 1'b1;
            chk_d  = idx_q[SLW-1:0];
            pend_d = 1'b1;
            if (op_q == OP_DRAIN) begin
              ack_re = 1'b1;
              head_d = (head_q == AAW'(ACK_QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
              acnt_d = acnt_q - 1'b1;
            end else begin
              slot_re = 1'b1;
            end
          end else begin
            pend_d = 1'b0;
            if (op_q == OP_ACK && !is_hit) begin
              hold_v_d    = 1'b1;
              hold_kind_d = K_UNKNOWN;
              hold_seq_d  = cur_seq_q;
            end
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_kind_d = hold_v_q ? hold_kind_q : K_NOTHING;
          out_seq_d  = hold_v_q ? hold_seq_q : '0;
          hold_v_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_NONE;
      next_out_q <= '0;
      next_exp_q <= '0;
      now_q      <= '0;
      valid_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      acnt_q     <= '0;
      idx_q      <= '0;
      limit_q    <= '0;
      pend_q     <= 1'b0;
      n_q        <= '0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      next_out_q <= next_out_d;
      next_exp_q <= next_exp_d;
      now_q      <= now_d;
      valid_q    <= valid_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      acnt_q     <= acnt_d;
      idx_q      <= idx_d;
      limit_q    <= limit_d;
      pend_q     <= pend_d;
      n_q        <= n_d;
      hold_v_q   <= hold_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_seq_q   <= cur_seq_d;
    chk_q       <= chk_d;
    hold_kind_q <= hold_kind_d;
    hold_seq_q  <= hold_seq_d;
    out_kind_q  <= out_kind_d;
    out_seq_q   <= out_seq_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign out_kind_o  = out_kind_q;
  assign out_seq_o   = out_seq_q;
  assign out_last_o  = out_last_q;

endmodule
